[hw/rtl/gclu_pkg.sv]
package gclu_pkg;

  // Default operand width; the lcm result is twice as wide.
  localparam int OPERAND_BITS = 31;

  // Microprogram addressing.
  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t S_IDLE      = 3'd0;
  localparam step_t S_CHECK     = 3'd1;
  localparam step_t S_STEIN     = 3'd2;
  localparam step_t S_GCD       = 3'd3;
  localparam step_t S_DIV       = 3'd4;
  localparam step_t S_MUL       = 3'd5;
  localparam step_t S_EMIT      = 3'd6;
  localparam step_t S_EMIT_ZERO = 3'd7;

  // Datapath operations.
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP       = 3'd0;
  localparam op_t OP_LOAD      = 3'd1;
  localparam op_t OP_STEIN     = 3'd2;
  localparam op_t OP_GCD       = 3'd3;
  localparam op_t OP_DIV       = 3'd4;
  localparam op_t OP_MUL       = 3'd5;
  localparam op_t OP_EMIT      = 3'd6;
  localparam op_t OP_EMIT_ZERO = 3'd7;

  // Jump conditions.
  typedef logic [2:0] cond_t;
  localparam cond_t C_ALWAYS      = 3'd0;
  localparam cond_t C_IN_XFER     = 3'd1;
  localparam cond_t C_BUSY        = 3'd2;
  localparam cond_t C_DIV_MORE    = 3'd3;
  localparam cond_t C_OUT_BLOCKED = 3'd4;
  localparam cond_t C_ZERO_IN     = 3'd5;

  // One control word: the operation, and where to go when the condition
  // holds or fails.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target_hit;
    step_t target_miss;
  } uword_t;

  // Status flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic busy;      // both Stein operands still nonzero
    logic div_more;  // divider has more quotient bits to produce
    logic zero_in;   // an operand of the current item is zero
  } dp_status_t;

  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:      w = '{OP_LOAD,      C_IN_XFER,     S_CHECK,     S_IDLE};
      S_CHECK:     w = '{OP_NOP,       C_ZERO_IN,     S_EMIT_ZERO, S_STEIN};
      S_STEIN:     w = '{OP_STEIN,     C_BUSY,        S_STEIN,     S_GCD};
      S_GCD:       w = '{OP_GCD,       C_ALWAYS,      S_DIV,       S_DIV};
      S_DIV:       w = '{OP_DIV,       C_DIV_MORE,    S_DIV,       S_MUL};
      S_MUL:       w = '{OP_MUL,       C_ALWAYS,      S_EMIT,      S_EMIT};
      S_EMIT:      w = '{OP_EMIT,      C_OUT_BLOCKED, S_EMIT,      S_IDLE};
      S_EMIT_ZERO: w = '{OP_EMIT_ZERO, C_OUT_BLOCKED, S_EMIT_ZERO, S_IDLE};
      default:     w = '{OP_NOP,       C_ALWAYS,      S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/gcd_lcm_unit_core.sv]
// An item runs through the operand load, check, Stein loop, gcd rebuild, divider, multiply and
// emit steps; an item with a zero operand goes from the check straight to its own emit step.
// One item is in work at a time and the next input transfer can be taken in the cycle after the
// result is loaded; while the output stalls, the load and so the next transfer wait. The Stein
// loop and the one-bit-per-cycle divider take most of an item's time.
// rst_n is synchronous and active low; it clears the step counter and output valid only.
module gcd_lcm_unit_core #(
  parameter int OPERAND_BITS = gclu_pkg::OPERAND_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OPERAND_BITS-1:0]     in_first_value,
  input  logic [OPERAND_BITS-1:0]     in_second_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [OPERAND_BITS-1:0]     out_gcd_value,
  output logic [2*OPERAND_BITS-1:0]   out_lcm_value,
  output logic                        out_zero_operand
);

  // The sequencer walks a fixed microprogram held in gclu_pkg::ucode_rom.
  // Each step issues one datapath operation and picks its successor from
  // a single condition flag:
  //   idle      load operands on an input transfer
  //   check     branch to the zero-operand exit if either operand is zero
  //   stein     binary gcd step, repeated while both operands are nonzero
  //   gcd       rebuild the gcd and prime the divider with the first operand
  //   div       one quotient bit per cycle of first / gcd
  //   mul       quotient times second operand gives the lcm
  //   emit      load the output register once it is free, then go idle

  gclu_pkg::step_t      pc_r, pc_nxt;
  gclu_pkg::uword_t     uword;
  gclu_pkg::op_t        dp_op;
  gclu_pkg::dp_status_t status;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_xfer;
  logic                 out_free;
  logic                 cond_hit;

  assign uword    = gclu_pkg::ucode_rom(pc_r);
  assign in_ready = (pc_r == gclu_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // The output register can take a new result when it is empty or its
  // current result transfers in this cycle.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (uword.cond)
      gclu_pkg::C_ALWAYS:      cond_hit = 1'b1;
      gclu_pkg::C_IN_XFER:     cond_hit = in_xfer;
      gclu_pkg::C_BUSY:        cond_hit = status.busy;
      gclu_pkg::C_DIV_MORE:    cond_hit = status.div_more;
      gclu_pkg::C_OUT_BLOCKED: cond_hit = !out_free;
      gclu_pkg::C_ZERO_IN:     cond_hit = status.zero_in;
      default:                 cond_hit = 1'b0;
    endcase
  end

  // Loads and result writes only happen when their handshake allows it;
  // otherwise the step waits and the datapath holds.
  always_comb begin
    dp_op = uword.op;
    if ((uword.op == gclu_pkg::OP_LOAD) && !in_xfer) begin
      dp_op = gclu_pkg::OP_NOP;
    end
    if (((uword.op == gclu_pkg::OP_EMIT) || (uword.op == gclu_pkg::OP_EMIT_ZERO)) &&
        !out_free) begin
      dp_op = gclu_pkg::OP_NOP;
    end
  end

  assign pc_nxt = cond_hit ? uword.target_hit : uword.target_miss;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((dp_op == gclu_pkg::OP_EMIT) || (dp_op == gclu_pkg::OP_EMIT_ZERO)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= gclu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  gclu_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk          (clk),
    .op           (dp_op),
    .first_value  (in_first_value),
    .second_value (in_second_value),
    .status       (status),
    .gcd_value    (out_gcd_value),
    .lcm_value    (out_lcm_value),
    .zero_operand (out_zero_operand)
  );

  assign out_valid = out_valid_r;

  // An input transfer always moves the sequencer to the operand check.
  a_xfer_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == gclu_pkg::S_CHECK))
    else $error("input transfer did not reach the operand check");

  // A zero operand goes from the operand check straight to the short exit.
  a_zero_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && ((in_first_value == '0) || (in_second_value == '0)))
      |=> ##1 (pc_r == gclu_pkg::S_EMIT_ZERO))
    else $error("zero operand did not take the short exit");

  // A new result only appears from one of the two emit steps.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(pc_r) == gclu_pkg::S_EMIT) || ($past(pc_r) == gclu_pkg::S_EMIT_ZERO))
    else $error("result valid raised outside an emit step");

  // A flagged result carries a zero lcm; an unflagged one a nonzero gcd.
  a_zero_lcm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_operand) |-> (out_lcm_value == '0))
    else $error("zero-operand result with nonzero lcm");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_zero_operand) |-> (out_gcd_value != '0))
    else $error("result without zero operand has zero gcd");

endmodule

[hw/rtl/gclu_datapath.sv]
module gclu_datapath #(
  parameter int OPERAND_BITS = gclu_pkg::OPERAND_BITS
) (
  input  logic                        clk,
  input  gclu_pkg::op_t               op,
  input  logic [OPERAND_BITS-1:0]     first_value,
  input  logic [OPERAND_BITS-1:0]     second_value,
  output gclu_pkg::dp_status_t        status,
  output logic [OPERAND_BITS-1:0]     gcd_value,
  output logic [2*OPERAND_BITS-1:0]   lcm_value,
  output logic                        zero_operand
);

  localparam int N  = OPERAND_BITS;
  localparam int KW = $clog2(OPERAND_BITS);

  logic [N-1:0]   a_r, b_r, u_r, v_r, g_r, rem_r, dq_r;
  logic [KW-1:0]  k_r, cnt_r;
  logic [2*N-1:0] prod_r;
  logic [N-1:0]   gcd_out_r;
  logic [2*N-1:0] lcm_out_r;
  logic           zero_out_r;

  logic [N-1:0]   u_nxt, v_nxt;
  logic [KW-1:0]  k_nxt;
  logic [N:0]     rem_sh, rem_diff;
  logic           take;

  // One Stein step. Common factors of two are counted in k first; after
  // that at least one operand stays odd.
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    priority if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // Restoring divide, one quotient bit per cycle; the dividend shifts out
  // of dq_r as quotient bits shift in.
  assign rem_sh   = {rem_r, dq_r[N-1]};
  assign rem_diff = rem_sh - {1'b0, g_r};
  assign take     = ~rem_diff[N];

  always_ff @(posedge clk) begin
    unique case (op)
      gclu_pkg::OP_LOAD: begin
        a_r <= first_value;
        b_r <= second_value;
        u_r <= first_value;
        v_r <= second_value;
        k_r <= '0;
      end
      gclu_pkg::OP_STEIN: begin
        if ((|u_r) && (|v_r)) begin
          u_r <= u_nxt;
          v_r <= v_nxt;
          k_r <= k_nxt;
        end
      end
      gclu_pkg::OP_GCD: begin
        g_r   <= (u_r | v_r) << k_r;
        rem_r <= '0;
        dq_r  <= a_r;
        cnt_r <= '0;
      end
      gclu_pkg::OP_DIV: begin
        rem_r <= take ? rem_diff[N-1:0] : rem_sh[N-1:0];
        dq_r  <= {dq_r[N-2:0], take};
        cnt_r <= cnt_r + KW'(1);
      end
      gclu_pkg::OP_MUL: begin
        prod_r <= {{N{1'b0}}, dq_r} * {{N{1'b0}}, b_r};
      end
      gclu_pkg::OP_EMIT: begin
        gcd_out_r  <= g_r;
        lcm_out_r  <= prod_r;
        zero_out_r <= 1'b0;
      end
      gclu_pkg::OP_EMIT_ZERO: begin
        gcd_out_r  <= a_r | b_r;
        lcm_out_r  <= '0;
        zero_out_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status.busy     = (|u_r) && (|v_r);
  assign status.div_more = (cnt_r != KW'(N - 1));
  assign status.zero_in  = (a_r == '0) || (b_r == '0);

  assign gcd_value    = gcd_out_r;
  assign lcm_value    = lcm_out_r;
  assign zero_operand = zero_out_r;

endmodule

[bench/gcd_lcm_checker.sv]
`timescale 1ns / 1ps

module gcd_lcm_checker #(
  parameter int OPERAND_BITS = gclu_pkg::OPERAND_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [OPERAND_BITS-1:0]   in_first_value,
  input  logic [OPERAND_BITS-1:0]   in_second_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [OPERAND_BITS-1:0]   out_gcd_value,
  input  logic [2*OPERAND_BITS-1:0] out_lcm_value,
  input  logic                      out_zero_operand,
  output int                        mismatch_count,
  output int                        awaited_count
);

  typedef struct {
    logic [OPERAND_BITS-1:0]   first_value;
    logic [OPERAND_BITS-1:0]   second_value;
    logic [OPERAND_BITS-1:0]   gcd_value;
    logic [2*OPERAND_BITS-1:0] lcm_value;
    logic                      zero_operand;
  } answer_t;

  answer_t awaited_answers[$];

  // Euclid's remainder loop; the lcm is (first / gcd) * second, which never
  // overflows the double-width field.
  function automatic answer_t gcd_lcm_of(input logic [OPERAND_BITS-1:0] a,
                                         input logic [OPERAND_BITS-1:0] b);
    logic [2*OPERAND_BITS-1:0] x;
    logic [2*OPERAND_BITS-1:0] y;
    logic [2*OPERAND_BITS-1:0] rem;
    answer_t ans;
    ans.first_value  = a;
    ans.second_value = b;
    if (a == '0 || b == '0) begin
      ans.gcd_value    = (a == '0) ? b : a;
      ans.lcm_value    = '0;
      ans.zero_operand = 1'b1;
    end else begin
      x = (2*OPERAND_BITS)'(a);
      y = (2*OPERAND_BITS)'(b);
      while (y != '0) begin
        rem = x % y;
        x   = y;
        y   = rem;
      end
      ans.gcd_value    = x[OPERAND_BITS-1:0];
      ans.lcm_value    = ((2*OPERAND_BITS)'(a) / x) * (2*OPERAND_BITS)'(b);
      ans.zero_operand = 1'b0;
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input answer_t ans,
                                 input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch in %s for (%0d, %0d): got %0d, expected %0d",
             $realtime, what, ans.first_value, ans.second_value, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    answer_t ans;
    if (!rst_n) begin
      awaited_answers.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          ans = '{default: '0};
          report_mismatch("unrequested result", ans, 64'(out_gcd_value), 64'(0));
        end else begin
          ans = awaited_answers.pop_front();
          if (out_gcd_value !== ans.gcd_value)
            report_mismatch("gcd_value", ans, 64'(out_gcd_value), 64'(ans.gcd_value));
          if (out_lcm_value !== ans.lcm_value)
            report_mismatch("lcm_value", ans, 64'(out_lcm_value), 64'(ans.lcm_value));
          if (out_zero_operand !== ans.zero_operand)
            report_mismatch("zero_operand", ans, 64'(out_zero_operand),
                            64'(ans.zero_operand));
        end
      end
      if (in_valid && in_ready)
        awaited_answers.push_back(gcd_lcm_of(in_first_value, in_second_value));
    end
    awaited_count = awaited_answers.size();
  end

endmodule

[bench/gcd_lcm_unit_core_test.sv]
`timescale 1ns / 1ps

module gcd_lcm_unit_core_test;

  localparam int N = gclu_pkg::OPERAND_BITS;
  localparam logic [N-1:0] MAX_OPERAND = {N{1'b1}};

  // Number of random operand pairs after the directed ones.
  localparam int RANDOM_PAIRS = 730;

  // Settling window after the last awaited result is seen, longer than the
  // slowest item takes in the core.
  localparam int DRAIN_CYCLES = 110;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [N-1:0]   in_first_value = '0;
  logic [N-1:0]   in_second_value = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [N-1:0]   out_gcd_value;
  logic [2*N-1:0] out_lcm_value;
  logic           out_zero_operand;

  int mismatch_count;
  int awaited_count;

  // While this is set, neither the sender nor the receiver ever idles, so a
  // long run of back-to-back transfers is exercised.
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gcd_lcm_unit_core #(
    .OPERAND_BITS(N)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_gcd_value    (out_gcd_value),
    .out_lcm_value    (out_lcm_value),
    .out_zero_operand (out_zero_operand)
  );

  gcd_lcm_checker #(
    .OPERAND_BITS(N)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_gcd_value    (out_gcd_value),
    .out_lcm_value    (out_lcm_value),
    .out_zero_operand (out_zero_operand),
    .mismatch_count   (mismatch_count),
    .awaited_count    (awaited_count)
  );

  // The receiver stalls with a chance of about 12 in 100, except while calm is set. The decision is
  // made on the falling edge so the core sees a stable ready at the rising
  // edge.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  // Present one operand pair and hold it until the transfer happens. The
  // task is entered and left on a falling edge. Valid is only lowered when
  // the sender decides to idle, so consecutive items keep valid high without
  // a glitch.
  task automatic send_pair(input logic [N-1:0] a, input logic [N-1:0] b);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_first_value  = a;
    in_second_value = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random operand pairs are shaped so that the interesting cases come up
  // often: zero operands, pairs with a large shared factor, one operand
  // dividing the other, powers of two, equal and neighboring values, small
  // values, besides plain full-range values that toggle every bit.
  task automatic send_random_pair();
    logic [N-1:0] a;
    logic [N-1:0] b;
    logic [N-1:0] g;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      a = N'($urandom & MAX_OPERAND);
      b = '0;
      case ($urandom_range(0, 2))
        0: {a, b} = {b, a};
        1: ;
        default: a = '0;
      endcase
    end else if (pick < 35) begin
      a = N'($urandom & MAX_OPERAND);
      b = N'($urandom & MAX_OPERAND);
    end else if (pick < 55) begin
      g = N'($urandom_range(1, 65535));
      a = N'(g * $urandom_range(1, MAX_OPERAND / g));
      b = N'(g * $urandom_range(1, MAX_OPERAND / g));
    end else if (pick < 70) begin
      a = N'($urandom_range(1, 1000));
      b = N'($urandom_range(1, 1000));
    end else if (pick < 80) begin
      a = N'($urandom_range(1, 65535));
      b = N'(a * $urandom_range(1, MAX_OPERAND / a));
      if ($urandom_range(0, 1) == 1) {a, b} = {b, a};
    end else if (pick < 90) begin
      a = N'(1) << $urandom_range(0, N - 1);
      b = N'($urandom & MAX_OPERAND) | N'(1);
      if ($urandom_range(0, 1) == 1) b = b << $urandom_range(0, 8);
    end else begin
      a = N'($urandom & MAX_OPERAND) | N'(1);
      b = ($urandom_range(0, 1) == 1) ? a : a - N'(1);
    end
    send_pair(a, b);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed pairs: both zero, one zero either side, the largest operand
    // against itself, one and its neighbor, a coprime pair at the top of the
    // range (largest lcm), powers of two, alternating bit patterns and a few
    // small textbook cases.
    send_pair('0, '0);
    send_pair('0, MAX_OPERAND);
    send_pair(MAX_OPERAND, '0);
    send_pair('0, N'(1));
    send_pair(N'(1), '0);
    send_pair(N'(1), N'(1));
    send_pair(MAX_OPERAND, MAX_OPERAND);
    send_pair(MAX_OPERAND, N'(1));
    send_pair(N'(1), MAX_OPERAND);
    send_pair(MAX_OPERAND, MAX_OPERAND - N'(1));
    send_pair(MAX_OPERAND - N'(1), MAX_OPERAND);
    send_pair(N'(1) << (N - 1), N'(1) << (N - 2));
    send_pair(N'(1) << (N - 1), MAX_OPERAND);
    send_pair(N'(1162261467), N'(1) << (N - 1));
    send_pair(N'(32'h5555_5555), N'(32'h2AAA_AAAA));
    send_pair(N'(65536), N'(65537));
    send_pair(N'(12), N'(18));
    send_pair(N'(18), N'(12));
    send_pair(N'(7), N'(7));
    send_pair(N'(1000000), N'(2500));

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      calm = (i >= 300 && i < 420);
      send_random_pair();
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    // Every accepted pair must come back before the verdict.
    while (awaited_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("gcd_lcm_unit_core_test passed");
    end else begin
      $display("gcd_lcm_unit_core_test failed");
    end
    $finish;
  end

  // Timeout for a hung run; a correct run finishes well before it.
  initial begin
    #2000000;
    $display("gcd_lcm_unit_core_test failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gclu_pkg.sv
hw/rtl/gclu_datapath.sv
hw/rtl/gcd_lcm_unit_core.sv
bench/gcd_lcm_checker.sv
bench/gcd_lcm_unit_core_test.sv
